@@ rtl/nmfd_pkg.sv @@
package nmfd_pkg;

  // Display geometry and timing; times in microseconds
  localparam int NUM_TUBES = 4;
  localparam int TICK_US   = 50;
  localparam int FRAME_US  = 16000;
  localparam int FADE_US   = 500000;

  localparam int FULL_US_I = 3000;
  localparam int DIM_US_I  = 50;
  localparam int SLOT_US_I = FRAME_US / NUM_TUBES;
  localparam int STEP_US_I = ((FADE_US / (FULL_US_I - DIM_US_I)) / TICK_US + 1) * TICK_US;

  // Fade timer only ever holds multiples of the tick, so a step is a tick count
  localparam int STEP_TICKS = STEP_US_I / TICK_US;
  localparam int PHASE_W    = (STEP_TICKS > 1) ? $clog2(STEP_TICKS) : 1;

  localparam int SLOT_W = 13;
  localparam int FADE_W = 19;
  localparam int ONT_W  = 12;

  localparam logic [SLOT_W-1:0] TICK_SLOT = SLOT_W'(TICK_US);
  localparam logic [SLOT_W-1:0] SLOT_US   = SLOT_W'(SLOT_US_I);
  localparam logic [FADE_W-1:0] TICK_FADE = FADE_W'(TICK_US);
  localparam logic [FADE_W-1:0] FADE_END  = FADE_W'(FADE_US);
  localparam logic [ONT_W-1:0]  FULL_US   = ONT_W'(FULL_US_I);
  localparam logic [ONT_W-1:0]  DIM_US    = ONT_W'(DIM_US_I);
  localparam logic [ONT_W-1:0]  ONT_MAX   = '1;
  localparam logic [3:0]        MAX_DIGIT = 4'd9;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(STEP_TICKS - 1);
  localparam logic [1:0]        LAST_TUBE = 2'(NUM_TUBES - 1);

  // Request function codes
  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_SET  = 2'd1,
    FN_DIM  = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  // Fade stage codes as presented on the result
  localparam logic [1:0] STAGE_FULL     = 2'd0;
  localparam logic [1:0] STAGE_FADE_IN  = 2'd1;
  localparam logic [1:0] STAGE_DIMMED   = 2'd2;
  localparam logic [1:0] STAGE_FADE_OUT = 2'd3;

  typedef enum logic [3:0] {
    FS_FULL     = 4'b0001,
    FS_FADE_IN  = 4'b0010,
    FS_DIMMED   = 4'b0100,
    FS_FADE_OUT = 4'b1000
  } fade_state_t;

  // One registered request
  typedef struct packed {
    logic [1:0] func;
    logic [1:0] tube;
    logic [3:0] digit;
    logic       dim_on;
  } item_t;

  function automatic logic [1:0] stage_code(input fade_state_t s);
    logic [1:0] c;
    case (s)
      FS_FULL:     c = STAGE_FULL;
      FS_FADE_IN:  c = STAGE_FADE_IN;
      FS_DIMMED:   c = STAGE_DIMMED;
      FS_FADE_OUT: c = STAGE_FADE_OUT;
      default:     c = STAGE_FULL;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/nmfd_if.sv @@
interface nmfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] tube;
  logic [3:0] digit;
  logic       dim_on;

  modport source (output valid, func, tube, digit, dim_on, input ready);
  modport sink   (input valid, func, tube, digit, dim_on, output ready);
endinterface

interface nmfd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  decoder_value;
  logic [3:0]  anode_mask;
  logic [1:0]  current_tube;
  logic [1:0]  fade_stage;
  logic [11:0] on_time_us;

  modport source (output valid, decoder_value, anode_mask, current_tube, fade_stage,
                  on_time_us, input ready);
  modport sink   (input valid, decoder_value, anode_mask, current_tube, fade_stage,
                  on_time_us, output ready);
endinterface

@@ rtl/nmfd_in_stage.sv @@
module nmfd_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  nmfd_pkg::item_t in_item,
  input  logic          advance,
  output logic          s1_valid,
  output nmfd_pkg::item_t s1_item
);
  import nmfd_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Take a new request when the stage is empty or the held one moves on this cycle
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

@@ rtl/nmfd_engine.sv @@
module nmfd_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            enable,
  input  logic            s1_valid,
  input  nmfd_pkg::item_t s1_item,
  output logic            advance,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [3:0]      out_decoder_value,
  output logic [3:0]      out_anode_mask,
  output logic [1:0]      out_current_tube,
  output logic [1:0]      out_fade_stage,
  output logic [11:0]     out_on_time_us
);
  import nmfd_pkg::*;

  // Display state
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [FADE_W-1:0]  fade_r, fade_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [ONT_W-1:0]   ont_r, ont_nxt;
  fade_state_t        fst_r, fst_nxt;
  logic [1:0]         scan_r, scan_nxt;
  logic [3:0]         store_r [NUM_TUBES];
  logic [3:0]         store_nxt [NUM_TUBES];
  logic [3:0]         lit_r, lit_nxt;
  logic [3:0]         dec_r, dec_nxt;

  // Result register
  logic               ovalid_r, ovalid_nxt;
  logic [3:0]         odec_r, olit_r;
  logic [1:0]         oscan_r, ostage_r;
  logic [ONT_W-1:0]   oont_r;

  logic               proc;
  logic               fading;

  assign advance = !ovalid_r || out_ready;
  assign proc    = s1_valid && advance;
  assign fading  = (fst_r == FS_FADE_IN) || (fst_r == FS_FADE_OUT);

  // Work out the state after the held request
  always_comb begin
    slot_nxt  = slot_r;
    fade_nxt  = fade_r;
    phase_nxt = phase_r;
    ont_nxt   = ont_r;
    fst_nxt   = fst_r;
    scan_nxt  = scan_r;
    lit_nxt   = lit_r;
    dec_nxt   = dec_r;
    for (int t = 0; t < NUM_TUBES; t++) begin
      store_nxt[t] = store_r[t];
    end

    if (proc) begin
      case (func_t'(s1_item.func))
        FN_TICK: begin
          if (enable) begin
            // Advance the fade and step the on-time
            if (fading) begin
              fade_nxt  = fade_r + TICK_FADE;
              phase_nxt = (phase_r == PHASE_LAST) ? '0 : phase_r + 1'b1;
              if (phase_nxt == '0) begin
                if (fst_r == FS_FADE_IN) begin
                  if (ont_r != '0) ont_nxt = ont_r - 1'b1;
                end else begin
                  if (ont_r != ONT_MAX) ont_nxt = ont_r + 1'b1;
                end
              end
              if (fade_nxt >= FADE_END) begin
                fade_nxt  = '0;
                phase_nxt = '0;
                if (fst_r == FS_FADE_IN) begin
                  fst_nxt = FS_DIMMED;
                  ont_nxt = DIM_US;
                end else begin
                  fst_nxt = FS_FULL;
                  ont_nxt = FULL_US;
                end
              end
            end
            // Advance the slot: drop the anode, then move the scan
            slot_nxt = slot_r + TICK_SLOT;
            if (slot_nxt >= {1'b0, ont_nxt}) begin
              lit_nxt[scan_r] = 1'b0;
            end
            if (slot_nxt >= SLOT_US) begin
              slot_nxt          = '0;
              scan_nxt          = (scan_r == LAST_TUBE) ? 2'd0 : scan_r + 2'd1;
              dec_nxt           = store_r[scan_nxt];
              lit_nxt[scan_nxt] = 1'b1;
            end
          end
        end
        FN_SET: begin
          store_nxt[s1_item.tube] = (s1_item.digit > MAX_DIGIT) ? MAX_DIGIT : s1_item.digit;
        end
        FN_DIM: begin
          if (s1_item.dim_on && fst_r == FS_DIMMED) begin
            fst_nxt = fst_r;
          end else if (!s1_item.dim_on && fst_r == FS_FULL) begin
            fst_nxt = fst_r;
          end else begin
            fst_nxt = s1_item.dim_on ? FS_FADE_IN : FS_FADE_OUT;
          end
        end
        default: begin
          fst_nxt = fst_r;
        end
      endcase
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (advance) begin
      ovalid_nxt = s1_valid;
    end
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      fade_r   <= '0;
      phase_r  <= '0;
      ont_r    <= FULL_US;
      fst_r    <= FS_FULL;
      scan_r   <= '0;
      lit_r    <= '0;
      dec_r    <= '0;
      ovalid_r <= 1'b0;
      for (int t = 0; t < NUM_TUBES; t++) begin
        store_r[t] <= '0;
      end
    end else begin
      slot_r   <= slot_nxt;
      fade_r   <= fade_nxt;
      phase_r  <= phase_nxt;
      ont_r    <= ont_nxt;
      fst_r    <= fst_nxt;
      scan_r   <= scan_nxt;
      lit_r    <= lit_nxt;
      dec_r    <= dec_nxt;
      ovalid_r <= ovalid_nxt;
      for (int t = 0; t < NUM_TUBES; t++) begin
        store_r[t] <= store_nxt[t];
      end
    end
  end

  // Load the result with the state after the request
  always_ff @(posedge clk) begin
    if (proc) begin
      odec_r   <= dec_nxt;
      olit_r   <= lit_nxt;
      oscan_r  <= scan_nxt;
      ostage_r <= stage_code(fst_nxt);
      oont_r   <= ont_nxt;
    end
  end

  assign out_valid         = ovalid_r;
  assign out_decoder_value = odec_r;
  assign out_anode_mask    = olit_r;
  assign out_current_tube  = oscan_r;
  assign out_fade_stage    = ostage_r;
  assign out_on_time_us    = oont_r;

endmodule

@@ rtl/nixie_multiplex_fade_driver_core.sv @@
// A request is held in the input register, then its state update is loaded into the
//   result register.
// Throughput: one request per cycle; the input register takes the next request
//   while a result waits, so only a stalled result register with a full input register
//   holds off requests.
// Reset: synchronous active-low rst_n clears all but the data registers; no clearing pass.
module nixie_multiplex_fade_driver_core (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  nmfd_in_if.sink    in_ch,
  nmfd_out_if.source out_ch
);
  import nmfd_pkg::*;

  logic  enable_r;
  logic  enable_nxt;
  logic  advance;
  logic  s1_valid;
  item_t in_item;
  item_t s1_item;

  // Hold the enable register
  assign enable_nxt = cfg_we ? cfg_wdata : enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
    end
  end

  assign in_item.func   = in_ch.func;
  assign in_item.tube   = in_ch.tube;
  assign in_item.digit  = in_ch.digit;
  assign in_item.dim_on = in_ch.dim_on;

  nmfd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  nmfd_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .enable            (enable_r),
    .s1_valid          (s1_valid),
    .s1_item           (s1_item),
    .advance           (advance),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_decoder_value (out_ch.decoder_value),
    .out_anode_mask    (out_ch.anode_mask),
    .out_current_tube  (out_ch.current_tube),
    .out_fade_stage    (out_ch.fade_stage),
    .out_on_time_us    (out_ch.on_time_us)
  );

`ifndef SYNTHESIS
  // Hold a stalled result steady until it is taken
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable({out_ch.decoder_value, out_ch.anode_mask,
                                out_ch.current_tube, out_ch.fade_stage,
                                out_ch.on_time_us})))
    else $error("stalled result changed");

  // Decoder never shows a non-BCD digit
  a_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.decoder_value <= MAX_DIGIT))
    else $error("decoder value above nine");

  // An empty result register never blocks requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("request stalled with empty result register");
`endif

endmodule
